/* rtl/enp_pkg.sv */
// shared constants, types and saturating helpers for the ellipse nearest point core
package enp_pkg;

   // default configuration of the core
   localparam int MAX_ITERATIONS_DEFAULT = 32;
   localparam int FRACTION_BITS_DEFAULT  = 16;

   // internal Q32.32 constants
   localparam logic signed [63:0] QLIM = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] QONE = 64'sh0000_0001_0000_0000;
   localparam logic signed [63:0] QTWO = 64'sh0000_0002_0000_0000;
   localparam logic signed [63:0] QEPS = 64'sh0000_0000_0000_0004;
   localparam logic [63:0]        ULIM = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [31:0]        M32  = 32'hFFFF_FFFF;

   // operations of the shared arithmetic unit
   typedef enum logic [2:0] {
      AOP_MUL  = 3'b001,
      AOP_DIV  = 3'b010,
      AOP_SQRT = 3'b100
   } arith_op_type;

   // request from the sequencer to the arithmetic unit
   typedef struct packed {
      logic         start;
      arith_op_type op;
   } arith_req_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_CENTER_X     = 3'd0,
      CSR_CENTER_Y     = 3'd1,
      CSR_AXIS_COS     = 3'd2,
      CSR_AXIS_SIN     = 3'd3,
      CSR_MAJOR_RADIUS = 3'd4,
      CSR_MINOR_RADIUS = 3'd5
   } csr_index_type;

   // magnitude of a Q32.32 value
   function automatic logic [63:0] mag(input logic signed [63:0] a);
      return a[63] ? 64'(-a) : 64'(a);
   endfunction

   // add with symmetric saturation to +-QLIM
   function automatic logic signed [63:0] addsat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
      logic signed [64:0] s;
      logic signed [64:0] hi;
      hi = 65'(QLIM);
      s  = 65'(a) + 65'(b);
      if (s > hi) begin
         return QLIM;
      end else if (s < -hi) begin
         return -QLIM;
      end
      return s[63:0];
   endfunction

endpackage

/* rtl/ellipse_nearest_point_core.sv */
// top level: nearest point on a configured ellipse by Newton iteration on a shared unit
//
// Takes one query point at a time and returns the nearest point on the ellipse, its
// distance and a valid flag; req_tready is low from acceptance until the result word is
// taken. Every multiply, divide and the final square root run on one shared unit, whose
// divide makes one quotient bit a cycle. A point on the major axis skips the Newton
// iteration; otherwise each Newton step takes three divides, eleven multiplies and the
// residual test, and the search gives up after MAX_ITERATIONS steps when the iteration
// does not converge. Configuration writes must be made while the core is idle.
module ellipse_nearest_point_core #(
   parameter int MAX_ITERATIONS = enp_pkg::MAX_ITERATIONS_DEFAULT,
   parameter int FRACTION_BITS  = enp_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] point_x, [63:32] point_y
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // [31:0] near_x, [63:32] near_y, [95:64] distance
   output logic [0:0]  rsp_tuser,   // [0] valid_res
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import enp_pkg::*;

   localparam int QSHIFT = 32 - FRACTION_BITS;
   localparam int ITER_W = $clog2(MAX_ITERATIONS);

   typedef enum logic [35:0] {
      ST_IDLE  = 36'd1 << 0,
      ST_MUC   = 36'd1 << 1,
      ST_MUS   = 36'd1 << 2,
      ST_MVC   = 36'd1 << 3,
      ST_MVS   = 36'd1 << 4,
      ST_CLASS = 36'd1 << 5,
      ST_TPREP = 36'd1 << 6,
      ST_TINIT = 36'd1 << 7,
      ST_LAA   = 36'd1 << 8,
      ST_LIA   = 36'd1 << 9,
      ST_LBB   = 36'd1 << 10,
      ST_LIB   = 36'd1 << 11,
      ST_LAU   = 36'd1 << 12,
      ST_LXA   = 36'd1 << 13,
      ST_LBV   = 36'd1 << 14,
      ST_LYB   = 36'd1 << 15,
      ST_LXA2  = 36'd1 << 16,
      ST_LYB2  = 36'd1 << 17,
      ST_LF    = 36'd1 << 18,
      ST_LDA   = 36'd1 << 19,
      ST_LDB   = 36'd1 << 20,
      ST_LFD   = 36'd1 << 21,
      ST_LRT   = 36'd1 << 22,
      ST_FRX   = 36'd1 << 23,
      ST_FRY   = 36'd1 << 24,
      ST_FD    = 36'd1 << 25,
      ST_DIST  = 36'd1 << 26,
      ST_UNF   = 36'd1 << 27,
      ST_OXC   = 36'd1 << 28,
      ST_OXS   = 36'd1 << 29,
      ST_OYS   = 36'd1 << 30,
      ST_OYC   = 36'd1 << 31,
      ST_OT    = 36'd1 << 32,
      ST_OFMT  = 36'd1 << 33,
      ST_FAIL  = 36'd1 << 34,
      ST_RESP  = 36'd1 << 35
   } state_type;

   // configuration registers
   logic signed [31:0] cx_ff, cy_ff, cos_ff, sin_ff;
   logic [30:0]        maj_ff, min_ff;

   state_type          state_ff, state_in;
   logic               issued_ff, issued_in;
   logic [ITER_W-1:0]  iter_ff, iter_in;
   logic               fold_ff, fold_in;
   logic               swap_ff, swap_in;
   logic signed [63:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [63:0] u_ff, u_in, v_ff, v_in;
   logic signed [63:0] a_ff, a_in, b_ff, b_in;
   logic signed [63:0] t_ff, t_in, m_ff, m_in, n_ff, n_in;
   logic signed [63:0] inva_ff, inva_in, invb_ff, invb_in;
   logic signed [63:0] xa_ff, xa_in, yb_ff, yb_in;
   logic signed [63:0] xa2_ff, xa2_in, yb2_ff, yb2_in;
   logic signed [63:0] f_ff, f_in;
   logic signed [63:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [31:0]        dist_ff, dist_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [31:0]        rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_dist_ff, rsp_dist_in;

   // shared unit hookup
   arith_req_type      arith_req;
   arith_op_type       aop_op;
   logic               aop_go;
   logic signed [63:0] aop_a, aop_b;
   logic               adone;
   logic signed [63:0] ares;

   logic signed [31:0] req_x, req_y;
   logic signed [63:0] c4, s4, vsel, ryf;

   // external fixed point (FRACTION_BITS fraction bits) to internal Q32.32
   function automatic logic signed [63:0] toq(input logic signed [32:0] v);
      return 64'(v) <<< QSHIFT;
   endfunction

   // internal fixed point to output format, floored and saturated
   function automatic logic [31:0] fromq(input logic signed [63:0] v);
      logic signed [63:0] r;
      r = v >>> QSHIFT;
      if (r > 64'sh0000_0000_7FFF_FFFF) begin
         return 32'h7FFF_FFFF;
      end else if (r < -64'sh0000_0000_8000_0000) begin
         return 32'h8000_0000;
      end
      return r[31:0];
   endfunction

   assign req_x = signed'(req_tdata[31:0]);
   assign req_y = signed'(req_tdata[63:32]);
   assign c4    = {{30{cos_ff[31]}}, cos_ff, 2'b00};
   assign s4    = {{30{sin_ff[31]}}, sin_ff, 2'b00};

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff  <= '0;
         cy_ff  <= '0;
         cos_ff <= 32'sh4000_0000;
         sin_ff <= '0;
         maj_ff <= 31'(64'd1 << FRACTION_BITS);
         min_ff <= 31'(64'd1 << FRACTION_BITS);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CENTER_X:     cx_ff  <= signed'(csr_wdata);
            CSR_CENTER_Y:     cy_ff  <= signed'(csr_wdata);
            CSR_AXIS_COS:     cos_ff <= signed'(csr_wdata);
            CSR_AXIS_SIN:     sin_ff <= signed'(csr_wdata);
            CSR_MAJOR_RADIUS: maj_ff <= csr_wdata[30:0];
            CSR_MINOR_RADIUS: min_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // operation and operands that each step hands to the shared unit
   always_comb begin
      aop_go = 1'b1;
      aop_op = AOP_MUL;
      aop_a  = dx_ff;
      aop_b  = c4;
      unique case (state_ff)
         ST_MUC: begin
            aop_a = dx_ff;
            aop_b = c4;
         end
         ST_MUS: begin
            aop_a = dy_ff;
            aop_b = s4;
         end
         ST_MVC: begin
            aop_a = dy_ff;
            aop_b = c4;
         end
         ST_MVS: begin
            aop_a = dx_ff;
            aop_b = s4;
         end
         ST_TINIT: begin
            aop_a = b_ff;
            aop_b = m_ff;
         end
         ST_LAA: begin
            aop_a = a_ff;
            aop_b = a_ff;
         end
         ST_LIA: begin
            aop_op = AOP_DIV;
            aop_a  = QONE;
            aop_b  = m_ff;
         end
         ST_LBB: begin
            aop_a = b_ff;
            aop_b = b_ff;
         end
         ST_LIB: begin
            aop_op = AOP_DIV;
            aop_a  = QONE;
            aop_b  = m_ff;
         end
         ST_LAU: begin
            aop_a = a_ff;
            aop_b = u_ff;
         end
         ST_LXA: begin
            aop_a = m_ff;
            aop_b = inva_ff;
         end
         ST_LBV: begin
            aop_a = b_ff;
            aop_b = v_ff;
         end
         ST_LYB: begin
            aop_a = m_ff;
            aop_b = invb_ff;
         end
         ST_LXA2: begin
            aop_a = xa_ff;
            aop_b = xa_ff;
         end
         ST_LYB2: begin
            aop_a = yb_ff;
            aop_b = yb_ff;
         end
         ST_LDA: begin
            aop_a = xa2_ff;
            aop_b = inva_ff;
         end
         ST_LDB: begin
            aop_a = yb2_ff;
            aop_b = invb_ff;
         end
         ST_LFD: begin
            aop_a = QTWO;
            aop_b = m_ff;
         end
         ST_LRT: begin
            aop_op = AOP_DIV;
            aop_a  = f_ff;
            aop_b  = m_ff;
         end
         ST_FRX: begin
            aop_a = xa_ff;
            aop_b = a_ff;
         end
         ST_FRY: begin
            aop_a = yb_ff;
            aop_b = b_ff;
         end
         ST_DIST: begin
            aop_op = AOP_SQRT;
            aop_a  = m_ff;
            aop_b  = n_ff;
         end
         ST_OXC: begin
            aop_a = rx_ff;
            aop_b = c4;
         end
         ST_OXS: begin
            aop_a = ry_ff;
            aop_b = s4;
         end
         ST_OYS: begin
            aop_a = rx_ff;
            aop_b = s4;
         end
         ST_OYC: begin
            aop_a = ry_ff;
            aop_b = c4;
         end
         default: aop_go = 1'b0;
      endcase
   end

   assign arith_req.start = aop_go && !issued_ff;
   assign arith_req.op    = aop_op;
   assign issued_in       = aop_go && !(issued_ff && adone);

   enp_arith #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_arith (
      .clock(clock),
      .reset(reset),
      .req  (arith_req),
      .opa  (aop_a),
      .opb  (aop_b),
      .done (adone),
      .res  (ares)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      iter_in      = iter_ff;
      fold_in      = fold_ff;
      swap_in      = swap_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      t_in         = t_ff;
      m_in         = m_ff;
      n_in         = n_ff;
      inva_in      = inva_ff;
      invb_in      = invb_ff;
      xa_in        = xa_ff;
      yb_in        = yb_ff;
      xa2_in       = xa2_ff;
      yb2_in       = yb2_ff;
      f_in         = f_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      dist_in      = dist_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_dist_in  = rsp_dist_ff;
      vsel         = (a_ff < b_ff) ? u_ff : v_ff;
      ryf          = fold_ff ? -ry_ff : ry_ff;

      unique case (state_ff)
         // take a point and move it to the center
         ST_IDLE: begin
            if (req_tvalid) begin
               dx_in    = toq(33'(req_x) - 33'(cx_ff));
               dy_in    = toq(33'(req_y) - 33'(cy_ff));
               a_in     = toq(signed'({2'b00, maj_ff}));
               b_in     = toq(signed'({2'b00, min_ff}));
               fold_in  = 1'b0;
               swap_in  = 1'b0;
               iter_in  = '0;
               state_in = ST_MUC;
            end
         end

         // rotate into the ellipse frame
         ST_MUC: if (adone) begin
            m_in     = ares;
            state_in = ST_MUS;
         end
         ST_MUS: if (adone) begin
            u_in     = addsat(m_ff, ares);
            state_in = ST_MVC;
         end
         ST_MVC: if (adone) begin
            m_in     = ares;
            state_in = ST_MVS;
         end
         ST_MVS: if (adone) begin
            v_in     = addsat(m_ff, -ares);
            state_in = ST_CLASS;
         end

         // major axis shortcut, else swap axes and fold to the upper half
         ST_CLASS: begin
            if (v_ff == '0) begin
               rx_in    = u_ff[63] ? -a_ff : a_ff;
               ry_in    = '0;
               state_in = ST_FD;
            end else begin
               if (a_ff < b_ff) begin
                  a_in    = b_ff;
                  b_in    = a_ff;
                  u_in    = v_ff;
                  swap_in = 1'b1;
               end
               if (vsel[63]) begin
                  v_in    = -vsel;
                  fold_in = 1'b1;
               end else begin
                  v_in = vsel;
               end
               state_in = ST_TPREP;
            end
         end
         ST_TPREP: begin
            m_in     = addsat(v_ff, -b_ff);
            state_in = ST_TINIT;
         end
         ST_TINIT: if (adone) begin
            t_in     = ares;
            state_in = ST_LAA;
         end

         // one Newton step
         ST_LAA: if (adone) begin
            m_in     = addsat(t_ff, ares);
            state_in = ST_LIA;
         end
         ST_LIA: if (adone) begin
            inva_in  = ares;
            state_in = ST_LBB;
         end
         ST_LBB: if (adone) begin
            m_in     = addsat(t_ff, ares);
            state_in = ST_LIB;
         end
         ST_LIB: if (adone) begin
            invb_in  = ares;
            state_in = ST_LAU;
         end
         ST_LAU: if (adone) begin
            m_in     = ares;
            state_in = ST_LXA;
         end
         ST_LXA: if (adone) begin
            xa_in    = ares;
            state_in = ST_LBV;
         end
         ST_LBV: if (adone) begin
            m_in     = ares;
            state_in = ST_LYB;
         end
         ST_LYB: if (adone) begin
            yb_in    = ares;
            state_in = ST_LXA2;
         end
         ST_LXA2: if (adone) begin
            xa2_in   = ares;
            state_in = ST_LYB2;
         end
         ST_LYB2: if (adone) begin
            yb2_in   = ares;
            m_in     = addsat(xa2_ff, ares);
            state_in = ST_LF;
         end
         ST_LF: begin
            f_in = addsat(m_ff, -QONE);
            if (f_in > -QEPS && f_in < QEPS) begin
               state_in = ST_FRX;
            end else begin
               state_in = ST_LDA;
            end
         end
         ST_LDA: if (adone) begin
            m_in     = ares;
            state_in = ST_LDB;
         end
         ST_LDB: if (adone) begin
            m_in     = addsat(m_ff, ares);
            state_in = ST_LFD;
         end
         ST_LFD: if (adone) begin
            m_in     = ares;
            state_in = ST_LRT;
         end
         ST_LRT: if (adone) begin
            if (ares > -QEPS && ares < QEPS) begin
               state_in = ST_FRX;
            end else begin
               t_in = addsat(t_ff, ares);
               if (iter_ff == ITER_W'(MAX_ITERATIONS - 1)) begin
                  state_in = ST_FAIL;
               end else begin
                  iter_in  = iter_ff + 1'b1;
                  state_in = ST_LAA;
               end
            end
         end

         // converged point and its distance
         ST_FRX: if (adone) begin
            rx_in    = ares;
            state_in = ST_FRY;
         end
         ST_FRY: if (adone) begin
            ry_in    = ares;
            state_in = ST_FD;
         end
         ST_FD: begin
            m_in     = addsat(rx_ff, -u_ff);
            n_in     = addsat(ry_ff, -v_ff);
            state_in = ST_DIST;
         end
         ST_DIST: if (adone) begin
            dist_in  = ares[31:0];
            state_in = ST_UNF;
         end

         // unfold, rotate back, move back
         ST_UNF: begin
            if (swap_ff) begin
               rx_in = ryf;
               ry_in = rx_ff;
            end else begin
               ry_in = ryf;
            end
            state_in = ST_OXC;
         end
         ST_OXC: if (adone) begin
            m_in     = ares;
            state_in = ST_OXS;
         end
         ST_OXS: if (adone) begin
            m_in     = addsat(m_ff, -ares);
            state_in = ST_OYS;
         end
         ST_OYS: if (adone) begin
            n_in     = ares;
            state_in = ST_OYC;
         end
         ST_OYC: if (adone) begin
            n_in     = addsat(n_ff, ares);
            state_in = ST_OT;
         end
         ST_OT: begin
            rx_in    = addsat(m_ff, toq(33'(cx_ff)));
            ry_in    = addsat(n_ff, toq(33'(cy_ff)));
            state_in = ST_OFMT;
         end
         ST_OFMT: begin
            rsp_x_in     = fromq(rx_ff);
            rsp_y_in     = fromq(ry_ff);
            rsp_dist_in  = dist_ff;
            rsp_ok_in    = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_RESP;
         end
         ST_FAIL: begin
            rsp_x_in     = '0;
            rsp_y_in     = '0;
            rsp_dist_in  = M32;
            rsp_ok_in    = 1'b0;
            rsp_valid_in = 1'b1;
            state_in     = ST_RESP;
         end

         // hold the result word until taken
         ST_RESP: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      iter_ff     <= iter_in;
      fold_ff     <= fold_in;
      swap_ff     <= swap_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      t_ff        <= t_in;
      m_ff        <= m_in;
      n_ff        <= n_in;
      inva_ff     <= inva_in;
      invb_ff     <= invb_in;
      xa_ff       <= xa_in;
      yb_ff       <= yb_in;
      xa2_ff      <= xa2_in;
      yb2_ff      <= yb2_in;
      f_ff        <= f_in;
      rx_ff       <= rx_in;
      ry_ff       <= ry_in;
      dist_ff     <= dist_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_dist_ff <= rsp_dist_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_dist_ff, rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = rsp_ok_ff;

   // an accepted word keeps the core busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("core ready right after accepting a word");

   // no new word while a result waits
   a_no_accept_with_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("core ready while a result is pending");

   // a failed search reports the saturated distance and a zero point
   a_fail_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |->
         (rsp_tdata[95:64] == M32 && rsp_tdata[63:0] == 64'h0))
      else $error("failed result word is malformed");

   // the shared unit start is never held high on consecutive cycles
   a_single_issue: assert property (@(posedge clock) disable iff (reset)
      arith_req.start |=> !arith_req.start)
      else $error("shared unit started twice in a row");

endmodule

/* rtl/enp_arith.sv */
// shared multi-cycle unit: saturating Q32.32 multiply, divide and the distance square root
module enp_arith #(
   parameter int FRACTION_BITS = enp_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  enp_pkg::arith_req_type req,
   input  logic signed [63:0]     opa,
   input  logic signed [63:0]     opb,
   output logic                   done,
   output logic signed [63:0]     res
);
   import enp_pkg::*;

   localparam int QSHIFT = 32 - FRACTION_BITS;

   typedef enum logic [6:0] {
      A_IDLE = 7'b0000001,
      A_MUL  = 7'b0000010,
      A_DCHK = 7'b0000100,
      A_DIV  = 7'b0001000,
      A_SQM  = 7'b0010000,
      A_SQRT = 7'b0100000,
      A_FIN  = 7'b1000000
   } astate_type;

   astate_type         state_ff, state_in;
   logic [63:0]        x_ff, x_in;
   logic [63:0]        y_ff, y_in;
   logic               neg_ff, neg_in;
   logic               nsgn_ff, nsgn_in;
   logic [63:0]        acc_ff, acc_in;
   logic [63:0]        r_ff, r_in;
   logic [65:0]        lo_ff, lo_in;
   logic [63:0]        pp_ff, pp_in;
   logic [6:0]         cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic signed [63:0] res_ff, res_in;

   logic [31:0] mul_a, mul_b;
   logic [64:0] r65, diff65;
   logic [36:0] rem37, trial37;
   logic [63:0] qn;
   logic [32:0] root_n;

   // add two magnitudes, capped at the saturation limit
   function automatic logic [63:0] ucap(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, ULIM}) ? ULIM : s[63:0];
   endfunction

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      neg_in   = neg_ff;
      nsgn_in  = nsgn_ff;
      acc_in   = acc_ff;
      r_in     = r_ff;
      lo_in    = lo_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      mul_a    = x_ff[31:0];
      mul_b    = y_ff[31:0];
      r65      = {r_ff, lo_ff[65]};
      diff65   = r65 - {1'b0, y_ff};
      rem37    = {r_ff[34:0], lo_ff[65:64]};
      trial37  = {acc_ff[34:0], 2'b01};
      qn       = acc_ff;
      root_n   = acc_ff[32:0];

      unique case (state_ff)
         A_IDLE: begin
            if (req.start) begin
               neg_in  = opa[63] ^ opb[63];
               nsgn_in = opa[63];
               cnt_in  = '0;
               acc_in  = '0;
               x_in    = mag(opa);
               y_in    = mag(opb);
               unique case (req.op)
                  AOP_MUL: state_in = A_MUL;
                  AOP_DIV: state_in = A_DCHK;
                  AOP_SQRT: begin
                     x_in     = mag(opa) >> QSHIFT;
                     y_in     = mag(opb) >> QSHIFT;
                     neg_in   = 1'b0;
                     state_in = A_SQM;
                  end
                  default: state_in = A_IDLE;
               endcase
            end
         end

         // four 32x32 partial products, high first, each registered and accumulated in the following cycle
         A_MUL: begin
            case (cnt_ff)
               7'd0: begin
                  mul_a = x_ff[63:32];
                  mul_b = y_ff[63:32];
               end
               7'd1: begin
                  mul_a = x_ff[31:0];
                  mul_b = y_ff[63:32];
               end
               7'd2: begin
                  mul_a = x_ff[63:32];
                  mul_b = y_ff[31:0];
               end
               default: begin
                  mul_a = x_ff[31:0];
                  mul_b = y_ff[31:0];
               end
            endcase
            case (cnt_ff) inside
               7'd1: acc_in = (pp_ff >= 64'h8000_0000) ? ULIM : {pp_ff[31:0], 32'h0};
               [7'd2:7'd3]: acc_in = ucap(acc_ff, pp_ff);
               7'd4: begin
                  acc_in   = ucap(acc_ff, {32'h0, pp_ff[63:32]});
                  state_in = A_FIN;
               end
               default: ;
            endcase
            cnt_in = cnt_ff + 7'd1;
         end

         // zero divisor and quotient overflow
         A_DCHK: begin
            if (y_ff == '0) begin
               acc_in   = (x_ff == '0) ? '0 : ULIM;
               neg_in   = nsgn_ff;
               state_in = A_FIN;
            end else if ({32'h0, x_ff[63:32]} >= y_ff) begin
               acc_in   = ULIM;
               state_in = A_FIN;
            end else begin
               r_in     = {32'h0, x_ff[63:32]};
               lo_in    = {x_ff[31:0], 34'h0};
               acc_in   = '0;
               cnt_in   = '0;
               state_in = A_DIV;
            end
         end

         // restoring division, one quotient bit a cycle
         A_DIV: begin
            if (r65 >= {1'b0, y_ff}) begin
               r_in = diff65[63:0];
               qn   = {acc_ff[62:0], 1'b1};
            end else begin
               r_in = r65[63:0];
               qn   = {acc_ff[62:0], 1'b0};
            end
            lo_in  = {lo_ff[64:0], 1'b0};
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) begin
               acc_in   = qn[63] ? ULIM : qn;
               state_in = A_FIN;
            end else begin
               acc_in = qn;
            end
         end

         // squares of the two deltas and their sum
         A_SQM: begin
            case (cnt_ff)
               7'd0: begin
                  mul_a = x_ff[31:0];
                  mul_b = x_ff[31:0];
                  if ((|x_ff[63:32]) || (|y_ff[63:32])) begin
                     acc_in   = {32'h0, M32};
                     state_in = A_FIN;
                  end
                  cnt_in = cnt_ff + 7'd1;
               end
               7'd1: begin
                  mul_a  = y_ff[31:0];
                  mul_b  = y_ff[31:0];
                  lo_in  = {2'b00, pp_ff};
                  cnt_in = cnt_ff + 7'd1;
               end
               default: begin
                  lo_in    = lo_ff + {2'b00, pp_ff};
                  r_in     = '0;
                  acc_in   = '0;
                  cnt_in   = '0;
                  state_in = A_SQRT;
               end
            endcase
         end

         // digit-by-digit square root, two radicand bits a cycle
         A_SQRT: begin
            if (rem37 >= trial37) begin
               r_in   = {27'h0, 37'(rem37 - trial37)};
               root_n = {acc_ff[31:0], 1'b1};
            end else begin
               r_in   = {27'h0, rem37};
               root_n = {acc_ff[31:0], 1'b0};
            end
            lo_in  = {lo_ff[63:0], 2'b00};
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd32) begin
               acc_in   = root_n[32] ? {32'h0, M32} : {31'h0, root_n};
               state_in = A_FIN;
            end else begin
               acc_in = {31'h0, root_n};
            end
         end

         A_FIN: begin
            res_in   = neg_ff ? signed'(64'(-acc_ff)) : signed'(acc_ff);
            done_in  = 1'b1;
            state_in = A_IDLE;
         end

         default: state_in = A_IDLE;
      endcase

      pp_in = 64'(mul_a) * 64'(mul_b);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      neg_ff  <= neg_in;
      nsgn_ff <= nsgn_in;
      acc_ff  <= acc_in;
      r_ff    <= r_in;
      lo_ff   <= lo_in;
      pp_ff   <= pp_in;
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule
